// File: design/pfe_pkg.sv
// shared constants, types and helpers of the palette fade engine
`timescale 1ns / 1ps
package pfe_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int FRACTION_BITS   = 16;
   localparam int COMP_COUNT      = 3 * PALETTE_ENTRIES;
   localparam int IDX_W           = $clog2(COMP_COUNT);

   localparam int LEVEL_W   = 6;
   localparam int MAX_LEVEL = 63;
   localparam int SHOWN_W   = 8;
   localparam int ACC_W     = LEVEL_W + 1 + FRACTION_BITS;
   localparam int DELTA_W   = LEVEL_W + FRACTION_BITS;
   localparam int QUO_W     = FRACTION_BITS + 1;
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);
   localparam int DTAB_DEPTH = 1 << LEVEL_W;

   localparam int TYPE_W    = 3;
   localparam int ENTRY_W   = 8;
   localparam int COMP_W    = 2;
   localparam int VALUE_W   = 8;
   localparam int STATUS_W  = 2;
   localparam int GAMMA_W   = 6;
   localparam int STEPS_W   = 12;
   localparam int K_W       = ENTRY_W + 2;

   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   localparam logic REG_GAMMA = 1'b0;
   localparam logic REG_STEPS = 1'b1;

   localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(32);
   localparam logic [COMP_W-1:0]  COMP_BLUE   = COMP_W'(2);

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD     = 3'd0,
      REQ_FADE_OUT = 3'd1,
      REQ_FADE_IN  = 3'd2,
      REQ_TICK     = 3'd3,
      REQ_READ     = 3'd4,
      REQ_CLEAR    = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_BUSY    = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_OUT  = 2'd1,
      DIR_IN   = 2'd2
   } dir_code_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ZERO,
      OP_CLEAR,
      OP_LOAD,
      OP_READ,
      OP_DIVIDE,
      OP_START,
      OP_TICK
   } op_code_type;

   typedef struct packed {
      logic [GAMMA_W-1:0] gamma;
      logic [STEPS_W-1:0] steps;
   } cfg_type;

   typedef struct packed {
      op_code_type          op;
      logic                 dir_out;
      logic                 show_base;
      logic [ENTRY_W-1:0]   entry;
      logic [COMP_W-1:0]    comp;
      logic [VALUE_W-1:0]   value;
   } dp_cmd_type;

   typedef struct packed {
      logic               done;
      logic [SHOWN_W-1:0] red;
      logic [SHOWN_W-1:0] green;
      logic [SHOWN_W-1:0] blue;
   } dp_stat_type;

   typedef struct packed {
      logic               we;
      logic [LEVEL_W-1:0] addr;
      logic [DELTA_W-1:0] data;
      logic               done;
   } div_wr_type;

   function automatic logic [STEPS_W-1:0] eff_steps(input logic [STEPS_W-1:0] s);
      return (s == '0) ? STEPS_W'(1) : s;
   endfunction

endpackage

// File: design/pfe_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface pfe_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfe_pkg::TYPE_W-1:0]   req_type;
   logic [pfe_pkg::ENTRY_W-1:0]  entry_index;
   logic [pfe_pkg::COMP_W-1:0]   component;
   logic [pfe_pkg::VALUE_W-1:0]  component_value;

   modport source (output valid, req_type, entry_index, component, component_value,
                   input ready);
   modport sink (input valid, req_type, entry_index, component, component_value,
                 output ready);
endinterface

interface pfe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfe_pkg::SHOWN_W-1:0]   red_out;
   logic [pfe_pkg::SHOWN_W-1:0]   green_out;
   logic [pfe_pkg::SHOWN_W-1:0]   blue_out;
   logic [pfe_pkg::STATUS_W-1:0]  status;
   logic                          faded_out;
   logic                          fade_active;

   modport source (output valid, red_out, green_out, blue_out, status, faded_out,
                   fade_active, input ready);
   modport sink (input valid, red_out, green_out, blue_out, status, faded_out,
                 fade_active, output ready);
endinterface

// File: design/palette_fade_engine_unit.sv
// palette fade engine top level: register port, controller and datapath
//
// req channel: one word per command (load, fade out, fade in, tick, read, clear);
// a word is taken when valid and ready are high at a clock edge.
// rsp channel: exactly one word per request, in order, with colours on a read,
// the status code and the faded and fade-active flags after the command.
// APB port: gamma offset at byte address 0, fade steps at 4; pready is always high.
// tick and clear make one pass over all 768 components through a 3-stage memory
// pipeline; a fade start runs a restoring divide, fills the 64-entry delta table,
// then makes the component pass. one command is in flight at a time; the next
// is taken while a response still waits in the output register.
// reset: synchronous; a sweep zeroes palette and display memories,
// ready stays low until it ends; register writes are taken throughout.
// a stalled receiver holds the response; a following command completes its
// work and then waits for the output register to free up.
`timescale 1ns / 1ps
module palette_fade_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   pfe_req_if.sink                           req,
   pfe_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pfe_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [pfe_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [pfe_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic [pfe_pkg::GAMMA_W-1:0]  gamma_ff;
   logic [pfe_pkg::STEPS_W-1:0]  steps_ff;
   pfe_pkg::cfg_type             cfg;
   pfe_pkg::dp_cmd_type          dp_cmd;
   pfe_pkg::dp_stat_type         dp_stat;

   assign pready = 1'b1;
   assign cfg    = '{gamma: gamma_ff, steps: steps_ff};

   always_comb begin
      unique case (paddr[2])
         pfe_pkg::REG_GAMMA: prdata = pfe_pkg::APB_DATA_W'(gamma_ff);
         pfe_pkg::REG_STEPS: prdata = pfe_pkg::APB_DATA_W'(steps_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= '0;
         steps_ff <= pfe_pkg::STEPS_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            pfe_pkg::REG_GAMMA: gamma_ff <= pwdata[pfe_pkg::GAMMA_W-1:0];
            pfe_pkg::REG_STEPS: steps_ff <= pwdata[pfe_pkg::STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   pfe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp),
      .cmd   (dp_cmd),
      .stat  (dp_stat)
   );

   pfe_dpath u_dpath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (dp_cmd),
      .stat  (dp_stat)
   );

`ifndef SYNTHESIS
   // a busy rejection can only be reported while a fade is running
   a_busy_means_active: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == pfe_pkg::STAT_BUSY) |-> rsp.fade_active)
      else $error("busy status without an active fade");

   // colours only come back from a successful read
   a_colour_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && ((rsp.red_out != '0) || (rsp.green_out != '0) ||
                    (rsp.blue_out != '0)) |-> (rsp.status == pfe_pkg::STAT_DONE))
      else $error("colour returned with non-done status");

   // no new command while the datapath is still finishing one
   a_no_accept_during_work: assert property (@(posedge clock) disable iff (reset)
      dp_stat.done |-> !req.ready)
      else $error("datapath completion while controller is idle");
`endif

endmodule

// File: design/pfe_div.sv
// delta table builder: one restoring divide, then 64 entries by accumulation
`timescale 1ns / 1ps
module pfe_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pfe_pkg::STEPS_W-1:0]   steps,
   output pfe_pkg::div_wr_type           wr
);

   typedef enum logic [1:0] {D_IDLE, D_DIV, D_FILL} div_state_type;

   div_state_type                     state_ff;
   logic [pfe_pkg::STEPS_W-1:0]       s_ff;
   logic [pfe_pkg::STEPS_W-1:0]       rem_ff;
   logic [pfe_pkg::QUO_W-1:0]         quo_ff;
   logic [pfe_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [pfe_pkg::LEVEL_W-1:0]       v_ff;
   logic [pfe_pkg::DELTA_W-1:0]       qa_ff;
   logic [pfe_pkg::STEPS_W-1:0]       ra_ff;
   logic                              done_ff;

   logic [pfe_pkg::STEPS_W:0]         trial_in;
   logic [pfe_pkg::STEPS_W:0]         trial_sub;
   logic                              ge;
   logic [pfe_pkg::STEPS_W:0]         rsum;
   logic                              carry;

   // dividend is 1 << FRACTION_BITS: only the first shifted-in bit is set
   assign trial_in  = {rem_ff, (cnt_ff == '0)};
   assign ge        = trial_in >= {1'b0, s_ff};
   assign trial_sub = trial_in - {1'b0, s_ff};
   // (v+1)/s = v/s + 1/s, with remainders carried
   assign rsum      = {1'b0, ra_ff} + {1'b0, rem_ff};
   assign carry     = rsum >= {1'b0, s_ff};

   assign wr = '{we: (state_ff == D_FILL), addr: v_ff, data: qa_ff, done: done_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  s_ff     <= pfe_pkg::eff_steps(steps);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_DIV;
               end
            end
            D_DIV: begin
               rem_ff <= ge ? trial_sub[pfe_pkg::STEPS_W-1:0] : trial_in[pfe_pkg::STEPS_W-1:0];
               quo_ff <= {quo_ff[pfe_pkg::QUO_W-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == pfe_pkg::DIV_CNT_W'(pfe_pkg::QUO_W - 1)) begin
                  v_ff     <= '0;
                  qa_ff    <= '0;
                  ra_ff    <= '0;
                  state_ff <= D_FILL;
               end
            end
            D_FILL: begin
               v_ff  <= v_ff + 1'b1;
               qa_ff <= qa_ff + pfe_pkg::DELTA_W'(quo_ff) + pfe_pkg::DELTA_W'(carry);
               ra_ff <= carry ? pfe_pkg::STEPS_W'(rsum - {1'b0, s_ff})
                              : rsum[pfe_pkg::STEPS_W-1:0];
               if (v_ff == '1) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

endmodule

// File: design/pfe_dpath.sv
// datapath: palette, accumulator, display and delta memories with the walk pipeline
`timescale 1ns / 1ps
module pfe_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  pfe_pkg::cfg_type      cfg,
   input  pfe_pkg::dp_cmd_type   cmd,
   output pfe_pkg::dp_stat_type  stat
);

   localparam int IW = pfe_pkg::IDX_W;
   localparam int FB = pfe_pkg::FRACTION_BITS;
   localparam int LW = pfe_pkg::LEVEL_W;
   localparam int AW = pfe_pkg::ACC_W;

   logic [LW-1:0]                   base_mem  [pfe_pkg::COMP_COUNT];
   logic [AW-1:0]                   acc_mem   [pfe_pkg::COMP_COUNT];
   logic [pfe_pkg::SHOWN_W-1:0]     shown_mem [pfe_pkg::COMP_COUNT];
   logic [pfe_pkg::DELTA_W-1:0]     dtab      [pfe_pkg::DTAB_DEPTH];

   pfe_pkg::op_code_type            mode_ff;
   logic                            issue_ff;
   logic [IW-1:0]                   idx_ff;
   logic [IW-1:0]                   hi_ff;
   logic                            p1_vld_ff;
   logic [IW-1:0]                   p1_idx_ff;
   logic                            p2_vld_ff;
   logic [IW-1:0]                   p2_idx_ff;
   logic [LW-1:0]                   base_rd_ff;
   logic [AW-1:0]                   acc_rd_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     shown_rd_ff;
   logic [LW-1:0]                   base_p2_ff;
   logic [AW-1:0]                   acc_p2_ff;
   logic [pfe_pkg::DELTA_W-1:0]     dtab_rd_ff;
   logic                            dir_out_ff;
   logic                            show_base_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     red_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     green_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     blue_ff;
   logic                            load_done_ff;

   pfe_pkg::div_wr_type             div_wr;

   logic [pfe_pkg::K_W-1:0]         entry3;
   logic [IW-1:0]                   read_lo;
   logic [IW-1:0]                   load_k;
   logic                            walk_cmd;
   logic                            load_cmd;
   logic                            walk_done;
   logic [LW-1:0]                   sat;
   logic [LW:0]                     load_level;
   logic [LW:0]                     lim_level;
   logic [AW-1:0]                   limit;
   logic [AW-1:0]                   d_ext;
   logic [AW-1:0]                   dec;
   logic [AW:0]                     inc;
   logic [AW:0]                     stepped;
   logic [AW-1:0]                   clamped;
   logic [pfe_pkg::SHOWN_W-1:0]     tick_shown;
   logic [AW-1:0]                   start_acc;

   logic                            base_we;
   logic [IW-1:0]                   base_wa;
   logic [LW-1:0]                   base_wd;
   logic                            shown_we;
   logic [IW-1:0]                   shown_wa;
   logic [pfe_pkg::SHOWN_W-1:0]     shown_wd;
   logic                            acc_we;
   logic [AW-1:0]                   acc_wd;

   function automatic logic [pfe_pkg::SHOWN_W-1:0] shown_of(input logic [LW:0] level);
      if (level > (LW + 1)'(pfe_pkg::MAX_LEVEL))
         return pfe_pkg::SHOWN_W'(pfe_pkg::MAX_LEVEL * 4);
      return {level[LW-1:0], 2'b00};
   endfunction

   pfe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == pfe_pkg::OP_DIVIDE),
      .steps (cfg.steps),
      .wr    (div_wr)
   );

   assign entry3   = {1'b0, cmd.entry, 1'b0} + {2'b00, cmd.entry};
   assign read_lo  = IW'(entry3);
   assign load_k   = IW'(entry3 + pfe_pkg::K_W'(cmd.comp));
   assign load_cmd = cmd.op == pfe_pkg::OP_LOAD;
   assign walk_cmd = (cmd.op == pfe_pkg::OP_ZERO) || (cmd.op == pfe_pkg::OP_CLEAR) ||
                     (cmd.op == pfe_pkg::OP_READ) || (cmd.op == pfe_pkg::OP_START) ||
                     (cmd.op == pfe_pkg::OP_TICK);
   assign walk_done = p2_vld_ff && (p2_idx_ff == hi_ff);

   assign sat = (cmd.value > pfe_pkg::VALUE_W'(pfe_pkg::MAX_LEVEL))
                ? LW'(pfe_pkg::MAX_LEVEL) : cmd.value[LW-1:0];
   assign load_level = {1'b0, sat} + {1'b0, cfg.gamma};

   // tick arithmetic on the stage-two component
   assign lim_level = {1'b0, base_p2_ff} + {1'b0, cfg.gamma};
   assign limit     = {lim_level, {FB{1'b0}}};
   assign d_ext     = AW'(dtab_rd_ff);
   assign dec       = (acc_p2_ff >= d_ext) ? acc_p2_ff - d_ext : '0;
   assign inc       = {1'b0, acc_p2_ff} + {1'b0, d_ext};
   assign stepped   = dir_out_ff ? {1'b0, dec} : inc;
   assign clamped   = (stepped > {1'b0, limit}) ? limit : stepped[AW-1:0];
   assign tick_shown = show_base_ff ? shown_of(lim_level) : shown_of(clamped[AW-1:FB]);
   assign start_acc = dir_out_ff ? {1'b0, base_p2_ff, {FB{1'b0}}} : '0;

   always_comb begin
      base_we  = load_cmd || (p2_vld_ff && (mode_ff == pfe_pkg::OP_ZERO));
      base_wa  = load_cmd ? load_k : p2_idx_ff;
      base_wd  = load_cmd ? sat : '0;
      shown_we = load_cmd ||
                 (p2_vld_ff && ((mode_ff == pfe_pkg::OP_ZERO) ||
                                (mode_ff == pfe_pkg::OP_CLEAR) ||
                                (mode_ff == pfe_pkg::OP_TICK)));
      shown_wa = load_cmd ? load_k : p2_idx_ff;
      if (load_cmd)
         shown_wd = shown_of(load_level);
      else if (mode_ff == pfe_pkg::OP_TICK)
         shown_wd = tick_shown;
      else
         shown_wd = '0;
      acc_we = p2_vld_ff && ((mode_ff == pfe_pkg::OP_START) || (mode_ff == pfe_pkg::OP_TICK));
      acc_wd = (mode_ff == pfe_pkg::OP_START) ? start_acc : clamped;
   end

   always_ff @(posedge clock) begin
      if (base_we)
         base_mem[base_wa] <= base_wd;
      base_rd_ff <= base_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_we)
         acc_mem[p2_idx_ff] <= acc_wd;
      acc_rd_ff <= acc_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (shown_we)
         shown_mem[shown_wa] <= shown_wd;
      shown_rd_ff <= shown_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (div_wr.we)
         dtab[div_wr.addr] <= div_wr.data;
      dtab_rd_ff <= dtab[base_rd_ff];
   end

   // walk pipeline: issue address, memory read, update and write back
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pfe_pkg::OP_NONE;
         issue_ff     <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         load_done_ff <= 1'b0;
      end else begin
         load_done_ff <= load_cmd;
         p1_vld_ff    <= issue_ff;
         p1_idx_ff    <= idx_ff;
         p2_vld_ff    <= p1_vld_ff;
         p2_idx_ff    <= p1_idx_ff;
         if (walk_cmd) begin
            mode_ff      <= cmd.op;
            issue_ff     <= 1'b1;
            dir_out_ff   <= cmd.dir_out;
            show_base_ff <= cmd.show_base;
            if (cmd.op == pfe_pkg::OP_READ) begin
               idx_ff <= read_lo;
               hi_ff  <= read_lo + IW'(2);
            end else begin
               idx_ff <= '0;
               hi_ff  <= IW'(pfe_pkg::COMP_COUNT - 1);
            end
         end else if (issue_ff) begin
            if (idx_ff == hi_ff)
               issue_ff <= 1'b0;
            else
               idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_p2_ff <= base_rd_ff;
      acc_p2_ff  <= acc_rd_ff;
      // red, green, blue arrive in order and shift into place
      if (p1_vld_ff && (mode_ff == pfe_pkg::OP_READ)) begin
         red_ff   <= green_ff;
         green_ff <= blue_ff;
         blue_ff  <= shown_rd_ff;
      end
   end

   assign stat = '{done: walk_done || load_done_ff || div_wr.done,
                   red: red_ff, green: green_ff, blue: blue_ff};

endmodule

// File: design/pfe_ctrl.sv
// controller: request decode, fade state, datapath sequencing and response register
`timescale 1ns / 1ps
module pfe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  pfe_pkg::cfg_type      cfg,
   pfe_req_if.sink               req,
   pfe_rsp_if.source             rsp,
   output pfe_pkg::dp_cmd_type   cmd,
   input  pfe_pkg::dp_stat_type  stat
);

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_BOOT_WAIT,
      ST_IDLE,
      ST_DECODE,
      ST_DIV_WAIT,
      ST_WAIT,
      ST_RESP
   } ctrl_state_type;

   ctrl_state_type                  state_ff;
   pfe_pkg::dp_cmd_type             cmd_ff;
   logic [pfe_pkg::TYPE_W-1:0]      type_ff;
   logic [pfe_pkg::ENTRY_W-1:0]     entry_ff;
   logic [pfe_pkg::COMP_W-1:0]      comp_ff;
   logic [pfe_pkg::VALUE_W-1:0]     value_ff;
   logic                            faded_ff;
   pfe_pkg::dir_code_type           dir_ff;
   logic [pfe_pkg::STEPS_W-1:0]     ticks_ff;
   pfe_pkg::status_code_type        status_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     red_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     green_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     blue_ff;
   logic                            rsp_valid_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     rsp_red_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     rsp_green_ff;
   logic [pfe_pkg::SHOWN_W-1:0]     rsp_blue_ff;
   logic [pfe_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic                            rsp_faded_ff;
   logic                            rsp_active_ff;

   logic                            busy;
   logic                            entry_ok;
   logic                            last_tick;
   logic                            want_out;

   assign busy      = ticks_ff != '0;
   assign entry_ok  = {1'b0, entry_ff} < (pfe_pkg::ENTRY_W + 1)'(pfe_pkg::PALETTE_ENTRIES);
   assign last_tick = ticks_ff == pfe_pkg::STEPS_W'(1);
   assign want_out  = type_ff == pfe_pkg::REQ_FADE_OUT;

   assign req.ready       = state_ff == ST_IDLE;
   assign cmd             = cmd_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.red_out     = rsp_red_ff;
   assign rsp.green_out   = rsp_green_ff;
   assign rsp.blue_out    = rsp_blue_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.faded_out   = rsp_faded_ff;
   assign rsp.fade_active = rsp_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         cmd_ff.op    <= pfe_pkg::OP_NONE;
         rsp_valid_ff <= 1'b0;
         faded_ff     <= 1'b0;
         dir_ff       <= pfe_pkg::DIR_IDLE;
         ticks_ff     <= '0;
      end else begin
         cmd_ff.op <= pfe_pkg::OP_NONE;
         if (rsp.ready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_BOOT: begin
               cmd_ff.op <= pfe_pkg::OP_ZERO;
               state_ff  <= ST_BOOT_WAIT;
            end
            ST_BOOT_WAIT: begin
               if (stat.done)
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req.valid) begin
                  type_ff  <= req.req_type;
                  entry_ff <= req.entry_index;
                  comp_ff  <= req.component;
                  value_ff <= req.component_value;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               red_ff         <= '0;
               green_ff       <= '0;
               blue_ff        <= '0;
               status_ff      <= pfe_pkg::STAT_DONE;
               state_ff       <= ST_RESP;
               cmd_ff.entry   <= entry_ff;
               cmd_ff.comp    <= comp_ff;
               cmd_ff.value   <= value_ff;
               cmd_ff.dir_out <= want_out;
               cmd_ff.show_base <= 1'b0;
               unique case (type_ff) inside
                  pfe_pkg::REQ_LOAD: begin
                     if (busy) begin
                        status_ff <= pfe_pkg::STAT_BUSY;
                     end else if (!entry_ok || comp_ff > pfe_pkg::COMP_BLUE) begin
                        status_ff <= pfe_pkg::STAT_IGNORED;
                     end else begin
                        cmd_ff.op <= pfe_pkg::OP_LOAD;
                        faded_ff  <= 1'b0;
                        state_ff  <= ST_WAIT;
                     end
                  end
                  pfe_pkg::REQ_FADE_OUT, pfe_pkg::REQ_FADE_IN: begin
                     if (busy) begin
                        status_ff <= pfe_pkg::STAT_BUSY;
                     end else if (want_out == faded_ff) begin
                        status_ff <= pfe_pkg::STAT_IGNORED;
                     end else begin
                        cmd_ff.op <= pfe_pkg::OP_DIVIDE;
                        state_ff  <= ST_DIV_WAIT;
                     end
                  end
                  pfe_pkg::REQ_TICK: begin
                     if (!busy) begin
                        status_ff <= pfe_pkg::STAT_IGNORED;
                     end else begin
                        cmd_ff.op        <= pfe_pkg::OP_TICK;
                        cmd_ff.dir_out   <= dir_ff == pfe_pkg::DIR_OUT;
                        cmd_ff.show_base <= last_tick && (dir_ff == pfe_pkg::DIR_IN);
                        ticks_ff         <= ticks_ff - 1'b1;
                        if (last_tick) begin
                           faded_ff <= dir_ff == pfe_pkg::DIR_OUT;
                           dir_ff   <= pfe_pkg::DIR_IDLE;
                        end
                        state_ff <= ST_WAIT;
                     end
                  end
                  pfe_pkg::REQ_READ: begin
                     if (!entry_ok) begin
                        status_ff <= pfe_pkg::STAT_IGNORED;
                     end else begin
                        cmd_ff.op <= pfe_pkg::OP_READ;
                        state_ff  <= ST_WAIT;
                     end
                  end
                  pfe_pkg::REQ_CLEAR: begin
                     if (busy) begin
                        status_ff <= pfe_pkg::STAT_BUSY;
                     end else begin
                        cmd_ff.op <= pfe_pkg::OP_CLEAR;
                        faded_ff  <= 1'b1;
                        state_ff  <= ST_WAIT;
                     end
                  end
                  default: status_ff <= pfe_pkg::STAT_IGNORED;
               endcase
            end
            ST_DIV_WAIT: begin
               // delta table ready, now seed the accumulators
               if (stat.done) begin
                  cmd_ff.op <= pfe_pkg::OP_START;
                  dir_ff    <= want_out ? pfe_pkg::DIR_OUT : pfe_pkg::DIR_IN;
                  ticks_ff  <= pfe_pkg::eff_steps(cfg.steps);
                  state_ff  <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (stat.done) begin
                  if (type_ff == pfe_pkg::REQ_READ) begin
                     red_ff   <= stat.red;
                     green_ff <= stat.green;
                     blue_ff  <= stat.blue;
                  end
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_red_ff    <= red_ff;
                  rsp_green_ff  <= green_ff;
                  rsp_blue_ff   <= blue_ff;
                  rsp_status_ff <= status_ff;
                  rsp_faded_ff  <= faded_ff;
                  rsp_active_ff <= busy;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_BOOT;
         endcase
      end
   end

endmodule

// File: test/palette_fade_engine_unit_test.sv
// self-checking testbench for the palette fade engine: random commands, fades and register phases
`timescale 1ns / 1ps
module palette_fade_engine_unit_test;

   typedef struct {
      logic [pfe_pkg::TYPE_W-1:0]  kind;
      logic [pfe_pkg::ENTRY_W-1:0] entry;
      logic [pfe_pkg::COMP_W-1:0]  comp;
      logic [pfe_pkg::VALUE_W-1:0] value;
   } command_type;

   typedef struct {
      logic [pfe_pkg::SHOWN_W-1:0]  red;
      logic [pfe_pkg::SHOWN_W-1:0]  green;
      logic [pfe_pkg::SHOWN_W-1:0]  blue;
      logic [pfe_pkg::STATUS_W-1:0] status;
      logic                         faded;
      logic                         active;
   } reply_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [pfe_pkg::APB_ADDR_W-1:0] csr_paddr;
   logic [pfe_pkg::APB_DATA_W-1:0] csr_pwdata, csr_prdata;

   pfe_req_if req_ch();
   pfe_rsp_if rsp_ch();

   palette_fade_engine_unit u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite), .paddr(csr_paddr),
      .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   // mirror of the block state
   logic [pfe_pkg::GAMMA_W-1:0]   gamma_cfg;
   logic [pfe_pkg::STEPS_W-1:0]   steps_cfg;
   logic [pfe_pkg::LEVEL_W-1:0]   base_lvl [pfe_pkg::COMP_COUNT];
   logic [31:0]                   fade_acc [pfe_pkg::COMP_COUNT];
   logic [31:0]                   fade_step [pfe_pkg::COMP_COUNT];
   logic [pfe_pkg::SHOWN_W-1:0]   shown [pfe_pkg::COMP_COUNT];
   logic                          faded_state;
   pfe_pkg::dir_code_type         direction;
   logic [pfe_pkg::STEPS_W-1:0]   ticks_left;

   command_type command_q[$];
   reply_type   reply_q[$];
   command_type held_cmd;
   int          mismatches;
   logic        calm;

   function automatic logic [pfe_pkg::SHOWN_W-1:0] level_to_shown(input logic [31:0] lvl);
      return (lvl > pfe_pkg::MAX_LEVEL) ? pfe_pkg::SHOWN_W'(pfe_pkg::MAX_LEVEL * 4)
                                        : pfe_pkg::SHOWN_W'(lvl * 4);
   endfunction

   task automatic show_base();
      for (int i = 0; i < pfe_pkg::COMP_COUNT; i++)
         shown[i] = level_to_shown(base_lvl[i] + gamma_cfg);
   endtask

   task automatic predict(input command_type c, output reply_type r);
      logic busy;
      logic [31:0] full, acc, lim, k, val;
      logic [pfe_pkg::STEPS_W-1:0] n;
      busy = (ticks_left != 0);
      r = '{default: '0};
      r.status = pfe_pkg::STAT_DONE;
      case (c.kind) inside
         pfe_pkg::REQ_LOAD: begin
            if (busy) r.status = pfe_pkg::STAT_BUSY;
            else if (c.comp > pfe_pkg::COMP_BLUE) r.status = pfe_pkg::STAT_IGNORED;
            else begin
               k = c.entry * 3 + c.comp;
               val = (c.value > pfe_pkg::MAX_LEVEL) ? pfe_pkg::MAX_LEVEL : c.value;
               base_lvl[k] = pfe_pkg::LEVEL_W'(val);
               shown[k] = level_to_shown(val + gamma_cfg);
               faded_state = 1'b0;
            end
         end
         pfe_pkg::REQ_FADE_OUT, pfe_pkg::REQ_FADE_IN: begin
            if (busy) r.status = pfe_pkg::STAT_BUSY;
            else if ((c.kind == pfe_pkg::REQ_FADE_OUT) == faded_state)
               r.status = pfe_pkg::STAT_IGNORED;
            else begin
               n = (steps_cfg == 0) ? pfe_pkg::STEPS_W'(1) : steps_cfg;
               for (int i = 0; i < pfe_pkg::COMP_COUNT; i++) begin
                  full = 32'(base_lvl[i]) << pfe_pkg::FRACTION_BITS;
                  fade_step[i] = full / n;
                  fade_acc[i] = (c.kind == pfe_pkg::REQ_FADE_OUT) ? full : 0;
               end
               direction = (c.kind == pfe_pkg::REQ_FADE_OUT) ? pfe_pkg::DIR_OUT
                                                             : pfe_pkg::DIR_IN;
               ticks_left = n;
            end
         end
         pfe_pkg::REQ_TICK: begin
            if (!busy) r.status = pfe_pkg::STAT_IGNORED;
            else begin
               for (int i = 0; i < pfe_pkg::COMP_COUNT; i++) begin
                  acc = fade_acc[i];
                  lim = (32'(base_lvl[i]) + gamma_cfg) << pfe_pkg::FRACTION_BITS;
                  if (direction == pfe_pkg::DIR_OUT)
                     acc = (acc >= fade_step[i]) ? acc - fade_step[i] : 0;
                  else acc = acc + fade_step[i];
                  if (acc > lim) acc = lim;
                  fade_acc[i] = acc & 32'h7F_FFFF;
                  shown[i] = level_to_shown(acc >> pfe_pkg::FRACTION_BITS);
               end
               ticks_left = ticks_left - 1;
               if (ticks_left == 0) begin
                  if (direction == pfe_pkg::DIR_OUT) faded_state = 1'b1;
                  else begin
                     show_base();
                     faded_state = 1'b0;
                  end
                  direction = pfe_pkg::DIR_IDLE;
               end
            end
         end
         pfe_pkg::REQ_READ: begin
            r.red = shown[c.entry * 3];
            r.green = shown[c.entry * 3 + 1];
            r.blue = shown[c.entry * 3 + 2];
         end
         pfe_pkg::REQ_CLEAR: begin
            if (busy) r.status = pfe_pkg::STAT_BUSY;
            else begin
               for (int i = 0; i < pfe_pkg::COMP_COUNT; i++) shown[i] = '0;
               faded_state = 1'b1;
            end
         end
         default: r.status = pfe_pkg::STAT_IGNORED;
      endcase
      r.faded = faded_state;
      r.active = (ticks_left != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      reply_type r;
      command_type c;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict(held_cmd, r);
            reply_q.push_back(r);
         end
         if ((!req_ch.valid || req_ch.ready) && command_q.size() != 0 &&
             (calm || $urandom_range(99) >= 9)) begin
            c = command_q.pop_front();
            held_cmd <= c;
            req_ch.valid <= 1'b1;
            req_ch.req_type <= c.kind;
            req_ch.entry_index <= c.entry;
            req_ch.component <= c.comp;
            req_ch.component_value <= c.value;
         end else if (!req_ch.valid || req_ch.ready) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reply_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reply word, status %0d", rsp_ch.status);
         end else begin
            e = reply_q.pop_front();
            if (rsp_ch.red_out !== e.red || rsp_ch.green_out !== e.green ||
                rsp_ch.blue_out !== e.blue || rsp_ch.status !== e.status ||
                rsp_ch.faded_out !== e.faded || rsp_ch.fade_active !== e.active) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp rgb %0d %0d %0d st %0d f %0d a %0d %s",
                     e.red, e.green, e.blue, e.status, e.faded, e.active,
                     $sformatf("got %0d %0d %0d st %0d f %0d a %0d",
                        rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                        rsp_ch.status, rsp_ch.faded_out, rsp_ch.fade_active));
            end
         end
      end
      rsp_ch.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 9);
   end

   task automatic push(input pfe_pkg::req_code_type k, input int e, input int cp,
                       input int v);
      command_type c;
      c.kind = k;
      c.entry = pfe_pkg::ENTRY_W'(e);
      c.comp = pfe_pkg::COMP_W'(cp);
      c.value = pfe_pkg::VALUE_W'(v);
      command_q.push_back(c);
   endtask

   task automatic push_random_load();
      push(pfe_pkg::REQ_LOAD, $urandom_range(255), $urandom_range(2), $urandom_range(255));
   endtask

   task automatic fade_run(input pfe_pkg::req_code_type k, input int extra);
      int n;
      n = (steps_cfg == 0) ? 1 : steps_cfg;
      push(k, 0, 0, 0);
      for (int i = 0; i < n + extra; i++) push(pfe_pkg::REQ_TICK, $urandom_range(255), 0, 0);
      push(pfe_pkg::REQ_READ, $urandom_range(255), 0, 0);
   endtask

   // sample at the falling edge so that queue and valid updates have settled
   task automatic drain();
      @(negedge clock);
      while (command_q.size() != 0 || req_ch.valid || reply_q.size() != 0) @(negedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (sel == pfe_pkg::REG_GAMMA) gamma_cfg = pfe_pkg::GAMMA_W'(data);
      else steps_cfg = pfe_pkg::STEPS_W'(data);
   endtask

   task automatic random_phase(input int count);
      int pick;
      while (command_q.size() < count) begin
         pick = $urandom_range(9);
         case (pick) inside
            [0:2]: repeat ($urandom_range(8, 1)) push_random_load();
            [3:4]: fade_run(pfe_pkg::REQ_FADE_OUT, $urandom_range(1));
            5: fade_run(pfe_pkg::REQ_FADE_IN, $urandom_range(1));
            6: push(pfe_pkg::REQ_CLEAR, 0, 0, 0);
            7: repeat ($urandom_range(4, 1)) push(pfe_pkg::REQ_READ, $urandom_range(255), 0, 0);
            default: push(pfe_pkg::req_code_type'($urandom_range(7)), $urandom_range(255),
                          $urandom_range(3), $urandom_range(255));
         endcase
      end
   endtask

   initial begin
      mismatches = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.entry_index = '0;
      req_ch.component = '0;
      req_ch.component_value = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gamma_cfg = '0;
      steps_cfg = pfe_pkg::STEPS_RESET;
      for (int i = 0; i < pfe_pkg::COMP_COUNT; i++) begin
         base_lvl[i] = '0;
         fade_acc[i] = '0;
         fade_step[i] = '0;
         shown[i] = '0;
      end
      faded_state = 1'b0;
      direction = pfe_pkg::DIR_IDLE;
      ticks_left = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, busy rejections, ignored cases
      csr_write(pfe_pkg::REG_STEPS, 3);
      csr_write(pfe_pkg::REG_GAMMA, 63);
      push(pfe_pkg::REQ_LOAD, 255, 2, 255);
      push(pfe_pkg::REQ_LOAD, 0, 0, 63);
      push(pfe_pkg::REQ_LOAD, 1, 1, 0);
      push(pfe_pkg::REQ_LOAD, 7, 3, 170);
      push(pfe_pkg::REQ_READ, 255, 0, 0);
      push(pfe_pkg::REQ_FADE_IN, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_FADE_OUT, 0, 0, 0);
      push(pfe_pkg::REQ_LOAD, 2, 0, 10);
      push(pfe_pkg::REQ_CLEAR, 0, 0, 0);
      push(pfe_pkg::REQ_FADE_IN, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_READ, 0, 0, 0);
      drain();
      // gamma changes mid fade
      csr_write(pfe_pkg::REG_GAMMA, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_FADE_OUT, 0, 0, 0);
      push(pfe_pkg::REQ_READ, 255, 0, 0);
      push(pfe_pkg::REQ_FADE_IN, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_TICK, 0, 0, 0);
      push(pfe_pkg::REQ_READ, 255, 0, 0);
      push(pfe_pkg::REQ_CLEAR, 0, 0, 0);
      push(pfe_pkg::REQ_READ, 0, 0, 0);
      push(pfe_pkg::req_code_type'(6), 0, 0, 0);
      push(pfe_pkg::req_code_type'(7), 0, 0, 0);
      drain();
      // zero and maximum step counts
      csr_write(pfe_pkg::REG_STEPS, 0);
      push(pfe_pkg::REQ_LOAD, 3, 0, 40);
      fade_run(pfe_pkg::REQ_FADE_OUT, 1);
      fade_run(pfe_pkg::REQ_FADE_IN, 0);
      drain();
      csr_write(pfe_pkg::REG_STEPS, 4095);
      push(pfe_pkg::REQ_FADE_IN, 0, 0, 0);
      push(pfe_pkg::REQ_READ, 3, 0, 0);
      drain();

      for (int phase = 0; phase < 14; phase++) begin
         csr_write(pfe_pkg::REG_GAMMA, $urandom_range(63));
         csr_write(pfe_pkg::REG_STEPS, (phase % 5 == 0) ? 1 : $urandom_range(6, 1));
         calm = (phase == 6 || phase == 7);
         random_phase(50);
         drain();
      end
      calm = 1'b0;
      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && reply_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(64'd20 * 64'd4_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
design/pfe_pkg.sv
design/pfe_if.sv
design/pfe_div.sv
design/pfe_dpath.sv
design/pfe_ctrl.sv
design/palette_fade_engine_unit.sv
test/palette_fade_engine_unit_test.sv
